// ===== hdl/sorted_list_insert_assert.svh =====
// ---------------------------------------------------------------------------
// sorted_list_insert_assert.svh
// Assertion macros shared by the sorted list insert block.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_ASSERT_SVH
`define SORTED_LIST_INSERT_ASSERT_SVH

// Condition holds at every clock edge outside reset
`define SLI_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define SLI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define SLI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/sli_pkg.sv =====
// ---------------------------------------------------------------------------
// sli_pkg
// Shared types and constants of the sorted list insert block.
// ---------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

   localparam int VALUE_W = 16;
   localparam int INDEX_W = 5;
   localparam int COUNT_W = 6;

   // One result transaction before packing onto the stream
   typedef struct packed {
      logic signed [VALUE_W-1:0] element_value;
      logic [INDEX_W-1:0]        element_index;
      logic                      last_of_run;
      logic                      rejected_full;
      logic [COUNT_W-1:0]        entry_count;
      logic [COUNT_W-1:0]        insert_position;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== hdl/sorted_list_insert.sv =====
// Operation: a full list answers with one rejecting result and takes no other value
// until that result is loaded. Otherwise the store is scanned one entry a cycle for the
// insert position, then the list is emitted one element a cycle while the result side
// does not stall. A new value is taken only once the last element has been emitted.
// Reset empties the list at once; the store itself is not cleared.
// ---------------------------------------------------------------------------
// sorted_list_insert
// Bounded ascending list of signed values with insert and full list readout.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert #(
   parameter int CAPACITY = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] new_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [15:0] element_value, [20:16] element_index,
                                         // [26:21] entry_count, [32:27] insert_position
   output logic             rsp_tlast,   // last_of_run
   output logic             rsp_tuser    // rejected_full
);

   localparam int AW    = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [sli_pkg::VALUE_W-1:0]   wr_data;
   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   logic [sli_pkg::VALUE_W-1:0]   rd_data;
   logic                          out_free;
   logic                          out_load;
   sli_pkg::rsp_item_type         out_item;
   sli_pkg::rsp_item_type         rsp_item;

   sli_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sli_seq #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .CNT_W    (CNT_W)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .new_value  (req_tdata),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .out_free   (out_free),
      .out_load   (out_load),
      .out_item   (out_item)
   );

   sli_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (out_load),
      .item       (out_item),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .item_q     (rsp_item)
   );

   // Pack the result transaction onto the stream
   assign rsp_tdata = {7'b0,
                       rsp_item.insert_position,
                       rsp_item.entry_count,
                       rsp_item.element_index,
                       rsp_item.element_value};
   assign rsp_tlast = rsp_item.last_of_run;
   assign rsp_tuser = rsp_item.rejected_full;

endmodule

`default_nettype wire

// ===== hdl/sli_mem.sv =====
// ---------------------------------------------------------------------------
// sli_mem
// Entry store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sli_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [AW-1:0]                 wr_addr,
   input  wire logic [sli_pkg::VALUE_W-1:0]   wr_data,
   input  wire logic                          rd_en,
   input  wire logic [AW-1:0]                 rd_addr,
   output logic      [sli_pkg::VALUE_W-1:0]   rd_data
);

   logic [sli_pkg::VALUE_W-1:0] store_ff [DEPTH];
   logic [sli_pkg::VALUE_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/sli_out.sv =====
// ---------------------------------------------------------------------------
// sli_out
// Result register: holds one transaction until the downstream side takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sli_out (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire sli_pkg::rsp_item_type item,
   output logic                       free,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output sli_pkg::rsp_item_type      item_q
);

   logic                  valid_ff;
   sli_pkg::rsp_item_type item_ff;

   assign free = !valid_ff || rsp_tready;

   // Valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (load && free) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign item_q     = item_ff;

endmodule

`default_nettype wire

// ===== hdl/sli_seq.sv =====
// ---------------------------------------------------------------------------
// sli_seq
// Sequencer: rejects on a full list, else scans the store for the insert
// position and walks the list again, emitting and writing back each entry.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_list_insert_assert.svh"

module sli_seq #(
   parameter int CAPACITY = 32,
   parameter int AW       = 5,
   parameter int CNT_W    = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [sli_pkg::VALUE_W-1:0]   new_value,
   output logic                               wr_en,
   output logic      [AW-1:0]                 wr_addr,
   output logic      [sli_pkg::VALUE_W-1:0]   wr_data,
   output logic                               rd_en,
   output logic      [AW-1:0]                 rd_addr,
   input  wire logic [sli_pkg::VALUE_W-1:0]   rd_data,
   input  wire logic                          out_free,
   output logic                               out_load,
   output sli_pkg::rsp_item_type              out_item
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_REJ  = 2'd3;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   logic [1:0]                          state_ff, state_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [AW-1:0]                       idx_ff, idx_in;
   logic [AW-1:0]                       pos_ff, pos_in;
   logic signed [sli_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic signed [sli_pkg::VALUE_W-1:0]  carry_ff, carry_in;

   logic signed [sli_pkg::VALUE_W-1:0]  rd_value;
   logic signed [sli_pkg::VALUE_W-1:0]  elem_value;
   logic [CNT_W-1:0]                    idx_ext;
   logic [CNT_W-1:0]                    idx_next_ext;
   logic [CNT_W-1:0]                    pos_ext;
   logic [CNT_W-1:0]                    count_plus;
   logic                                last_elem;
   logic [AW+sli_pkg::INDEX_W-1:0]      idx_wide;
   logic [CNT_W+sli_pkg::COUNT_W-1:0]   count_plus_wide;
   logic [CNT_W+sli_pkg::COUNT_W-1:0]   count_wide;
   logic [AW+sli_pkg::COUNT_W-1:0]      pos_wide;

   assign rd_value     = $signed(rd_data);
   assign idx_ext      = CNT_W'(idx_ff);
   assign idx_next_ext = idx_ext + 1'b1;
   assign pos_ext      = CNT_W'(pos_ff);
   assign count_plus   = count_ff + 1'b1;
   assign last_elem    = (idx_ext == count_ff);

   // Resize list positions and counts to the result field widths
   assign idx_wide        = {{sli_pkg::INDEX_W{1'b0}}, idx_ff};
   assign count_plus_wide = {{sli_pkg::COUNT_W{1'b0}}, count_plus};
   assign count_wide      = {{sli_pkg::COUNT_W{1'b0}}, count_ff};
   assign pos_wide        = {{sli_pkg::COUNT_W{1'b0}}, pos_ff};

   // Element at the current position after the insert
   always_comb begin
      if (idx_ff < pos_ff) begin
         elem_value = rd_value;
      end else if (idx_ff == pos_ff) begin
         elem_value = value_ff;
      end else begin
         elem_value = carry_ff;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   // Next state, memory accesses and result load
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      value_in = value_ff;
      carry_in = carry_ff;
      rd_en    = 1'b0;
      rd_addr  = idx_ff;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = elem_value;
      out_load = 1'b0;
      out_item.element_value   = elem_value;
      out_item.element_index   = idx_wide[sli_pkg::INDEX_W-1:0];
      out_item.last_of_run     = last_elem;
      out_item.rejected_full   = 1'b0;
      out_item.entry_count     = count_plus_wide[sli_pkg::COUNT_W-1:0];
      out_item.insert_position = pos_wide[sli_pkg::COUNT_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               value_in = $signed(new_value);
               idx_in   = '0;
               rd_addr  = '0;
               if (count_ff >= CAP_CNT) begin
                  state_in = ST_REJ;
               end else if (count_ff == '0) begin
                  pos_in   = '0;
                  rd_en    = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Stop at the first entry not smaller than the new value
            if (!(rd_value < value_ff)) begin
               pos_in   = idx_ff;
               idx_in   = '0;
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = ST_EMIT;
            end else if (idx_next_ext == count_ff) begin
               pos_in   = count_ff[AW-1:0];
               idx_in   = '0;
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = ST_EMIT;
            end else begin
               idx_in  = idx_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = idx_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            // Emit one element, write it back, fetch the next
            if (out_free) begin
               out_load = 1'b1;
               wr_en    = 1'b1;
               carry_in = rd_value;
               if (last_elem) begin
                  count_in = count_plus;
                  state_in = ST_IDLE;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end
         ST_REJ: begin
            out_item.element_value   = '0;
            out_item.element_index   = '0;
            out_item.last_of_run     = 1'b1;
            out_item.rejected_full   = 1'b1;
            out_item.entry_count     = count_wide[sli_pkg::COUNT_W-1:0];
            out_item.insert_position = count_wide[sli_pkg::COUNT_W-1:0];
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      value_ff <= value_in;
      carry_ff <= carry_in;
   end

   `SLI_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CAP_CNT, "count above capacity")
   `SLI_ASSERT_IMP(a_emit_range, clock, reset, state_ff == ST_EMIT, (idx_ext <= count_ff) && (pos_ext <= count_ff), "emit index or position beyond list end")
   `SLI_ASSERT_NXT(a_emit_done, clock, reset, (state_ff == ST_EMIT) && out_load && last_elem, (state_ff == ST_IDLE) && (count_ff == $past(count_plus)), "list end not followed by idle with count advanced")
   `SLI_ASSERT_IMP(a_write_emit, clock, reset, wr_en, state_ff == ST_EMIT, "store written outside emission")

endmodule

`default_nettype wire

// ===== dv/sli_result_checker.sv =====
// ---------------------------------------------------------------------------
// sli_result_checker
// Watches both streams of the sorted list insert block. Keeps its own copy of
// the ordered list, works out the full readout or the rejection each accepted
// value causes, and compares every result transaction field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module sli_result_checker #(
   parameter int CAPACITY = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] new_value
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,   // [15:0] element_value, [20:16] element_index,
                                         // [26:21] entry_count, [32:27] insert_position
   input  wire logic        rsp_tlast,   // last_of_run
   input  wire logic        rsp_tuser,   // rejected_full
   output int               mismatch_count,
   output int               outstanding_results
);

   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the ordered list
   logic signed [sli_pkg::VALUE_W-1:0] shadow_list [CAPACITY];
   int                                 shadow_count = 0;

   // Readout transactions still to arrive, oldest first
   sli_pkg::rsp_item_type              pending_readout [$];

   initial begin
      mismatch_count      = 0;
      outstanding_results = 0;
   end

   // Insert one value into the shadow list and queue the readout it causes
   function automatic void insert_and_queue_readout(
      logic signed [sli_pkg::VALUE_W-1:0] value);
      int                    pos;
      sli_pkg::rsp_item_type item;
      item = '0;
      // Full list: drop the value, answer with one rejecting transaction
      if (shadow_count >= CAPACITY) begin
         item.last_of_run     = 1'b1;
         item.rejected_full   = 1'b1;
         item.entry_count     = sli_pkg::COUNT_W'(shadow_count);
         item.insert_position = sli_pkg::COUNT_W'(shadow_count);
         pending_readout.push_back(item);
         return;
      end
      // Place before the first entry that is not smaller
      pos = 0;
      while (pos < shadow_count && shadow_list[pos] < value) pos++;
      for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
      shadow_list[pos] = value;
      shadow_count++;
      // Emit the whole list from the smallest entry up
      for (int i = 0; i < shadow_count; i++) begin
         item.element_value   = shadow_list[i];
         item.element_index   = sli_pkg::INDEX_W'(i);
         item.last_of_run     = (i == shadow_count - 1);
         item.rejected_full   = 1'b0;
         item.entry_count     = sli_pkg::COUNT_W'(shadow_count);
         item.insert_position = sli_pkg::COUNT_W'(pos);
         pending_readout.push_back(item);
      end
   endfunction

   function automatic void compare_field(string name, int expected, int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, got %0d", name, expected, actual);
         mismatch_count++;
      end
   endfunction

   // Compare a received transaction with the oldest expectation
   function automatic void check_readout();
      sli_pkg::rsp_item_type want;
      if (pending_readout.size() == 0) begin
         $error("result transaction with none expected: tdata %h tlast %b tuser %b",
                rsp_tdata, rsp_tlast, rsp_tuser);
         mismatch_count++;
         return;
      end
      want = pending_readout.pop_front();
      compare_field("element_value", int'(want.element_value),
                    int'($signed(rsp_tdata[15:0])));
      compare_field("element_index", int'(want.element_index), int'(rsp_tdata[20:16]));
      compare_field("entry_count", int'(want.entry_count), int'(rsp_tdata[26:21]));
      compare_field("insert_position", int'(want.insert_position), int'(rsp_tdata[32:27]));
      compare_field("last_of_run", int'(want.last_of_run), int'(rsp_tlast));
      compare_field("rejected_full", int'(want.rejected_full), int'(rsp_tuser));
      compare_field("tdata padding", 0, int'(rsp_tdata[39:33]));
   endfunction

   // Sample both channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         pending_readout.delete();
         outstanding_results <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_readout();
         if (req_tvalid && req_tready) insert_and_queue_readout($signed(req_tdata));
         outstanding_results <= pending_readout.size();
      end
   end

endmodule

`default_nettype wire

// ===== dv/tb_sorted_list_insert.sv =====
// ---------------------------------------------------------------------------
// tb_sorted_list_insert
// Drives values into the sorted list insert block: a directed set of edge
// values, equal values and bit patterns, then random values in bursts until
// the list is full and beyond. The result side stalls on its own pattern,
// including one long hold-off. Checking is done by the result checker.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_sorted_list_insert;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH     = 32;
   localparam int DIRECTED_COUNT = 25;
   localparam int ITEM_TOTAL     = 350;
   localparam int DRAIN_AT       = 150;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 2 * LIST_DEPTH + 8;

   // Edge values, equal values (front, middle, end) and alternating bit patterns
   localparam logic [15:0] DIRECTED_VALUES [DIRECTED_COUNT] = '{
      16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
      16'h0000, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA,
      16'h00FF, 16'hFF00, 16'h0064, 16'hFF9C, 16'h0032,
      16'h0032, 16'h0031, 16'h0033, 16'hFFFE, 16'h0002,
      16'h3039, 16'hCFC7, 16'h0100, 16'hFF00, 16'h03E8
   };

   typedef enum logic [1:0] {
      SINK_FREE,
      SINK_RANDOM,
      SINK_PERIODIC
   } sink_style_e;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_tvalid   = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata    = '0;   // [15:0] new_value
   logic        rsp_tvalid;
   logic        rsp_tready   = 1'b0;
   logic [39:0] rsp_tdata;           // [15:0] element_value, [20:16] element_index,
                                     // [26:21] entry_count, [32:27] insert_position
   logic        rsp_tlast;           // last_of_run
   logic        rsp_tuser;           // rejected_full
   logic        hold_request = 1'b0;
   logic        hold_served  = 1'b0;
   int          mismatch_count;
   int          outstanding_results;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   sorted_list_insert #(
      .CAPACITY(LIST_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   sli_result_checker #(
      .CAPACITY(LIST_DEPTH)
   ) u_result_check (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tlast          (rsp_tlast),
      .rsp_tuser          (rsp_tuser),
      .mismatch_count     (mismatch_count),
      .outstanding_results(outstanding_results)
   );

   // Offer one value and hold it until the transaction completes
   task automatic send_value(logic [15:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic pause_sender(int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Wait until every queued result has arrived
   task automatic wait_drained();
      @(posedge clock);
      while (outstanding_results != 0) @(posedge clock);
   endtask

   // Mostly full range; some values near zero to force equal entries, some extremes
   function automatic logic [15:0] random_value();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 8) + 16'hFFFC);
         1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
         default: return 16'($urandom());
      endcase
   endfunction

   // Sender: directed values, then random values in bursts with gaps
   initial begin : stimulus
      int burst_left;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int n = 0; n < ITEM_TOTAL; n++) begin
         if (n == DRAIN_AT) begin
            pause_sender(1);
            wait_drained();
            burst_left = 0;
         end
         if (burst_left == 0) begin
            if ($urandom_range(0, 9) == 0) pause_sender(40);
            else if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 8));
            burst_left = $urandom_range(1, 16);
         end
         // Ask for the long receiver hold-off while the list is still filling
         if (n == DIRECTED_COUNT) hold_request <= 1'b1;
         send_value(n < DIRECTED_COUNT ? DIRECTED_VALUES[n] : random_value());
         burst_left--;
      end
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding_results == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Receiver: alternate free, random and periodic stalling, one long hold-off
   initial begin : response_sink
      sink_style_e style;
      int          phase_len;
      while (reset) @(posedge clock);
      forever begin
         style     = sink_style_e'($urandom_range(0, 2));
         phase_len = $urandom_range(16, 96);
         for (int c = 0; c < phase_len; c++) begin
            if (hold_request && !hold_served) begin
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_served = 1'b1;
            end
            case (style)
               SINK_FREE:     rsp_tready <= 1'b1;
               SINK_RANDOM:   rsp_tready <= 1'($urandom_range(0, 1));
               SINK_PERIODIC: rsp_tready <= (c % 4 != 3);
               default:       rsp_tready <= 1'b1;
            endcase
            @(posedge clock);
         end
      end
   end

   // Give up on a hung run
   initial begin : watchdog
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
